### hw/rtl/rpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared widths and types for the ray/patch intersection pipeline.
// ----------------------------------------------------------------------------
package rpi_pkg;

	// Input formats.
	localparam int CW = 20;            // coordinate width
	localparam int FB = 8;             // fraction bits
	localparam int TW = 24;            // t bound width
	localparam int CORNER_W = 3 * CW;  // packed corner register width
	localparam int NCORNER = 4;
	localparam int IDX_W = 2;

	// Internal widths.
	localparam int EW = CW + 1;        // edge and offset components
	localparam int PW = 2 * EW;        // cross product terms
	localparam int XW = PW + 1;        // cross product components
	localparam int TPW = XW + EW;      // dot product terms
	localparam int SW = TPW + 2;       // dot product sums
	localparam int NW = SW + 1;        // sign corrected values
	localparam int LOW = (NW + 1) / 2; // low slice of det for the t products
	localparam int HIW = NW - LOW;     // high slice of det
	localparam int PPW = TW + LOW + 1; // partial product width
	localparam int MW = TW + NW;       // full t times det width

	// Pipeline depth: eight stages in each triangle unit plus the output stage.
	localparam int NS = 9;

	typedef logic [2:0][EW-1:0] vec_t;
	typedef logic [NS-1:0] stage_en_t;

endpackage
`default_nettype wire

### hw/rtl/rpi_tri.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_tri
// Eight-stage Moller-Trumbore test of one ray against one triangle.
// ----------------------------------------------------------------------------
module rpi_tri (
	input  wire logic              clk,
	input  wire rpi_pkg::stage_en_t en,
	input  wire rpi_pkg::vec_t      org,
	input  wire rpi_pkg::vec_t      dir,
	input  wire logic [rpi_pkg::TW-1:0] t_lo,
	input  wire logic [rpi_pkg::TW-1:0] t_hi,
	input  wire rpi_pkg::vec_t      p1,
	input  wire rpi_pkg::vec_t      p2,
	input  wire rpi_pkg::vec_t      p3,
	output logic                    hit_s8
);

	localparam int EW = rpi_pkg::EW;
	localparam int PW = rpi_pkg::PW;
	localparam int XW = rpi_pkg::XW;
	localparam int TPW = rpi_pkg::TPW;
	localparam int SW = rpi_pkg::SW;
	localparam int NW = rpi_pkg::NW;
	localparam int TW = rpi_pkg::TW;
	localparam int LOW = rpi_pkg::LOW;
	localparam int HIW = rpi_pkg::HIW;
	localparam int PPW = rpi_pkg::PPW;
	localparam int MW = rpi_pkg::MW;

	// Stage 1: edges and origin offset.
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], dv_s1 [3], dir_s1 [3];
	logic signed [TW-1:0] tlo_s1, thi_s1;
	// Stage 2: cross product terms.
	logic signed [PW-1:0] s1a_s2 [3], s1b_s2 [3], s2a_s2 [3], s2b_s2 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], dv_s2 [3], dir_s2 [3];
	logic signed [TW-1:0] tlo_s2, thi_s2;
	// Stage 3: cross products.
	logic signed [XW-1:0] s1_s3 [3], s2_s3 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], dv_s3 [3], dir_s3 [3];
	logic signed [TW-1:0] tlo_s3, thi_s3;
	// Stage 4: dot product terms.
	logic signed [TPW-1:0] dt_s4 [3], n1t_s4 [3], n2t_s4 [3], ntt_s4 [3];
	logic signed [TW-1:0] tlo_s4, thi_s4;
	// Stage 5: dot products.
	logic signed [SW-1:0] det_s5, n1_s5, n2_s5, nt_s5;
	logic signed [TW-1:0] tlo_s5, thi_s5;
	// Stage 6: sign corrected.
	logic signed [NW-1:0] det_s6, n1_s6, n2_s6, nt_s6;
	logic signed [TW-1:0] tlo_s6, thi_s6;
	// Stage 7: barycentric verdict and t partial products.
	logic                 bary_ok_s7;
	logic signed [MW-1:0] tsc_s7;
	logic signed [PPW-1:0] lolo_s7, lohi_s7, hilo_s7, hihi_s7;

	// Stage 1: edge vectors and offset from the first corner.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i]  <= $signed(p2[i]) - $signed(p1[i]);
				e2_s1[i]  <= $signed(p3[i]) - $signed(p1[i]);
				dv_s1[i]  <= $signed(org[i]) - $signed(p1[i]);
				dir_s1[i] <= $signed(dir[i]);
			end
			tlo_s1 <= $signed(t_lo);
			thi_s1 <= $signed(t_hi);
		end
	end

	// Stage 2: the products of s1 = dir x e2 and s2 = dv x e1.
	for (genvar g = 0; g < 3; g++) begin : g_cross
		localparam int J = (g + 1) % 3;
		localparam int K = (g + 2) % 3;
		always_ff @(posedge clk) begin
			if (en[1]) begin
				s1a_s2[g] <= PW'(dir_s1[J] * e2_s1[K]);
				s1b_s2[g] <= PW'(dir_s1[K] * e2_s1[J]);
				s2a_s2[g] <= PW'(dv_s1[J] * e1_s1[K]);
				s2b_s2[g] <= PW'(dv_s1[K] * e1_s1[J]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			e1_s2 <= e1_s1;
			e2_s2 <= e2_s1;
			dv_s2 <= dv_s1;
			dir_s2 <= dir_s1;
			tlo_s2 <= tlo_s1;
			thi_s2 <= thi_s1;
		end
	end

	// Stage 3: cross product differences.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				s1_s3[i] <= XW'(s1a_s2[i]) - XW'(s1b_s2[i]);
				s2_s3[i] <= XW'(s2a_s2[i]) - XW'(s2b_s2[i]);
			end
			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			dv_s3 <= dv_s2;
			dir_s3 <= dir_s2;
			tlo_s3 <= tlo_s2;
			thi_s3 <= thi_s2;
		end
	end

	// Stage 4: dot product terms for det, n1, n2 and nt.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				dt_s4[i]  <= TPW'(s1_s3[i] * e1_s3[i]);
				n1t_s4[i] <= TPW'(s1_s3[i] * dv_s3[i]);
				n2t_s4[i] <= TPW'(s2_s3[i] * dir_s3[i]);
				ntt_s4[i] <= TPW'(s2_s3[i] * e2_s3[i]);
			end
			tlo_s4 <= tlo_s3;
			thi_s4 <= thi_s3;
		end
	end

	// Stage 5: sum the terms.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			det_s5 <= SW'(dt_s4[0]) + SW'(dt_s4[1]) + SW'(dt_s4[2]);
			n1_s5  <= SW'(n1t_s4[0]) + SW'(n1t_s4[1]) + SW'(n1t_s4[2]);
			n2_s5  <= SW'(n2t_s4[0]) + SW'(n2t_s4[1]) + SW'(n2t_s4[2]);
			nt_s5  <= SW'(ntt_s4[0]) + SW'(ntt_s4[1]) + SW'(ntt_s4[2]);
			tlo_s5 <= tlo_s4;
			thi_s5 <= thi_s4;
		end
	end

	// Stage 6: flip signs so that the determinant is never negative.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			if (det_s5[SW-1]) begin
				det_s6 <= -NW'(det_s5);
				n1_s6  <= -NW'(n1_s5);
				n2_s6  <= -NW'(n2_s5);
				nt_s6  <= -NW'(nt_s5);
			end else begin
				det_s6 <= NW'(det_s5);
				n1_s6  <= NW'(n1_s5);
				n2_s6  <= NW'(n2_s5);
				nt_s6  <= NW'(nt_s5);
			end
			tlo_s6 <= tlo_s5;
			thi_s6 <= thi_s5;
		end
	end

	// Stage 7: barycentric range checks, and t bounds times det in two slices.
	logic signed [NW:0] bsum;
	logic signed [LOW:0] det_lo;
	logic signed [HIW-1:0] det_hi;
	assign bsum = (NW+1)'(n1_s6) + (NW+1)'(n2_s6);
	assign det_lo = $signed({1'b0, det_s6[LOW-1:0]});
	assign det_hi = det_s6[NW-1:LOW];

	always_ff @(posedge clk) begin
		if (en[6]) begin
			bary_ok_s7 <= (det_s6 != '0) && !n1_s6[NW-1] && (n1_s6 <= det_s6) &&
				!n2_s6[NW-1] && (bsum <= (NW+1)'(det_s6));
			tsc_s7  <= MW'(nt_s6) <<< rpi_pkg::FB;
			lolo_s7 <= PPW'(tlo_s6 * det_lo);
			lohi_s7 <= PPW'(tlo_s6 * det_hi);
			hilo_s7 <= PPW'(thi_s6 * det_lo);
			hihi_s7 <= PPW'(thi_s6 * det_hi);
		end
	end

	// Stage 8: recombine the slices and check t against both bounds.
	logic signed [MW-1:0] tlo_det, thi_det;
	assign tlo_det = (MW'(lohi_s7) <<< LOW) + MW'(lolo_s7);
	assign thi_det = (MW'(hihi_s7) <<< LOW) + MW'(hilo_s7);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			hit_s8 <= bary_ok_s7 && (tsc_s7 >= tlo_det) && (tsc_s7 <= thi_det);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/ray_patch_intersect_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_patch_intersect_core
// Tests rays against a four-corner patch split into two triangles.
// ----------------------------------------------------------------------------
// Usage:
//   Corners are written through cfg_we/cfg_index/cfg_data; index k sets corner
//   k as packed x, y, z signed coordinates. Write them while no ray is in
//   flight. Rays enter on the in_valid/in_ready channel, one beat per ray, and
//   each ray yields one beat with the hit flag on out_valid/out_ready.
//   A new ray may enter in every cycle while out_ready stays high, so the
//   sustained rate is then one ray per cycle, set by the nine-stage pipeline
//   in which both triangles run side by side. Each stage holds its beat only
//   while the stage after it is occupied and stalled, so a stall on out_ready
//   fills empty stages first and then pulls in_ready low; nothing is lost or
//   repeated. Reset clears the corner registers to zero and empties the
//   pipeline.
// ----------------------------------------------------------------------------
module ray_patch_intersect_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [rpi_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rpi_pkg::CORNER_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic signed [rpi_pkg::CW-1:0] origin_x,
	input  wire logic signed [rpi_pkg::CW-1:0] origin_y,
	input  wire logic signed [rpi_pkg::CW-1:0] origin_z,
	input  wire logic signed [rpi_pkg::CW-1:0] dir_x,
	input  wire logic signed [rpi_pkg::CW-1:0] dir_y,
	input  wire logic signed [rpi_pkg::CW-1:0] dir_z,
	input  wire logic signed [rpi_pkg::TW-1:0] t_min,
	input  wire logic signed [rpi_pkg::TW-1:0] t_max,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      hit
);

	localparam int CW = rpi_pkg::CW;
	localparam int EW = rpi_pkg::EW;
	localparam int NS = rpi_pkg::NS;

	logic [rpi_pkg::CORNER_W-1:0] corner_q [rpi_pkg::NCORNER];
	rpi_pkg::vec_t cv [rpi_pkg::NCORNER];
	rpi_pkg::vec_t org, dir;
	rpi_pkg::stage_en_t en;
	logic [NS-1:0] valid_q;
	logic hit_a, hit_b;

	// Corner registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < rpi_pkg::NCORNER; k++) corner_q[k] <= '0;
		end else if (cfg_we) begin
			corner_q[cfg_index] <= cfg_data;
		end
	end

	// Unpack corners and sign-extend the ray to the edge width.
	always_comb begin
		for (int k = 0; k < rpi_pkg::NCORNER; k++) begin
			for (int i = 0; i < 3; i++) begin
				cv[k][i] = EW'($signed(corner_q[k][CW*i +: CW]));
			end
		end
		org[0] = EW'(origin_x);
		org[1] = EW'(origin_y);
		org[2] = EW'(origin_z);
		dir[0] = EW'(dir_x);
		dir[1] = EW'(dir_y);
		dir[2] = EW'(dir_z);
	end

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		en[NS-1] = !valid_q[NS-1] || out_ready;
		for (int s = NS - 2; s >= 0; s--) begin
			en[s] = !valid_q[s] || en[s+1];
		end
	end

	assign in_ready = en[0];

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= in_valid;
			for (int s = 1; s < NS; s++) begin
				if (en[s]) valid_q[s] <= valid_q[s-1];
			end
		end
	end

	// Triangle (0,1,2).
	rpi_tri u_tri_a (
		.clk(clk), .en(en), .org(org), .dir(dir), .t_lo(t_min), .t_hi(t_max),
		.p1(cv[0]), .p2(cv[1]), .p3(cv[2]), .hit_s8(hit_a)
	);

	// Triangle (3,2,1).
	rpi_tri u_tri_b (
		.clk(clk), .en(en), .org(org), .dir(dir), .t_lo(t_min), .t_hi(t_max),
		.p1(cv[3]), .p2(cv[2]), .p3(cv[1]), .hit_s8(hit_b)
	);

	// Output stage: either triangle hit.
	logic hit_s9;
	always_ff @(posedge clk) begin
		if (en[NS-1]) hit_s9 <= hit_a || hit_b;
	end

	assign out_valid = valid_q[NS-1];
	assign hit = hit_s9;

endmodule
`default_nettype wire
